// ===== hdl/tea_block_encrypt_assert.svh =====
// Assertion macros for the TEA block encryptor port-level checker.
// Expects clk_i and rst_ni to exist in the scope where a macro is used.
`ifndef TEA_BLOCK_ENCRYPT_ASSERT_SVH
`define TEA_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TEA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/tea_pkg.sv =====
// Package for the TEA block encryptor: types, round constants and key reset values.
// Used by every module of the encryptor; depends on nothing.
package tea_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned STAGE_COUNT = 2 * ROUND_COUNT;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_COUNT = 4;
  localparam int unsigned CFG_IDX_W = $clog2(KEY_COUNT);

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e3779b9;

  localparam logic [WORD_W-1:0] KEY_RESET [KEY_COUNT] = '{
    32'hd1d2a3a4, 32'hb5e8f5c6, 32'he23f4a78, 32'h0f4e6cf9
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    KEY_IDX_0 = 2'd0,
    KEY_IDX_1 = 2'd1,
    KEY_IDX_2 = 2'd2,
    KEY_IDX_3 = 2'd3
  } key_idx_e;

  typedef enum logic {
    HALF_LEFT  = 1'b0,
    HALF_RIGHT = 1'b1
  } half_e;

  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } tea_blk_t;

  // Running sum for a round numbered from one, modulo 2^32.
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned rnd);
    logic [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(rnd) * (2*WORD_W)'(TEA_DELTA);
    return prod[WORD_W-1:0];
  endfunction

endpackage

// ===== hdl/tea_stage.sv =====
// One pipeline stage of the TEA encryptor: a registered half-round.
// Depends on tea_pkg.
module tea_stage import tea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  half_e             half_i,
  input  logic [WORD_W-1:0] sum_i,
  input  logic [WORD_W-1:0] ka_i,
  input  logic [WORD_W-1:0] kb_i,
  input  logic              valid_i,
  input  tea_blk_t          blk_i,
  output logic              valid_o,
  output tea_blk_t          blk_o
);

  logic              valid_q;
  tea_blk_t          blk_q, blk_d;
  logic [WORD_W-1:0] src, upd, mix_a, mix_b, mix_c, mix;

  always_comb begin
    src   = (half_i == HALF_LEFT) ? blk_i.right : blk_i.left;
    upd   = (half_i == HALF_LEFT) ? blk_i.left : blk_i.right;
    mix_a = (src << 4) + ka_i;
    mix_b = src + sum_i;
    mix_c = (src >> 5) + kb_i;
    mix   = mix_a ^ mix_b ^ mix_c;
    blk_d = blk_i;
    if (half_i == HALF_LEFT) begin
      blk_d.left = upd + mix;
    end else begin
      blk_d.right = upd + mix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

// ===== hdl/tea_skid.sv =====
// Output skid register that decouples the pipeline from a stalled consumer.
// Depends on tea_pkg.
module tea_skid import tea_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     last_valid_i,
  input  tea_blk_t last_blk_i,
  input  logic     out_ready_i,
  output logic     adv_o,
  output logic     out_valid_o,
  output tea_blk_t out_blk_o
);

  logic     skid_valid_q, skid_valid_d;
  tea_blk_t skid_blk_q;

  always_comb begin
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_d = 1'b0;
      end
    end else if (last_valid_i && !out_ready_i) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q && last_valid_i && !out_ready_i) begin
      skid_blk_q <= last_blk_i;
    end
  end

  assign adv_o       = !skid_valid_q;
  assign out_valid_o = skid_valid_q || last_valid_i;
  assign out_blk_o   = skid_valid_q ? skid_blk_q : last_blk_i;

endmodule

// ===== hdl/tea_block_encrypt.sv =====
// TEA block encryptor, 32 rounds, one half-round per register stage (64 stages).
// Each word passes through every stage in order; throughput one word per cycle while the skid is empty.
// The stage chain sets the latency; a one-entry output skid keeps input acceptance registered.
// Reset clears all valid bits and loads the four key registers with their default constants.
// Depends on tea_pkg, tea_stage and tea_skid.
module tea_block_encrypt import tea_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [WORD_W-1:0]    plain_left_i,
  input  logic [WORD_W-1:0]    plain_right_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_W-1:0]    cipher_left_o,
  output logic [WORD_W-1:0]    cipher_right_o
);

  logic [WORD_W-1:0] key_q [KEY_COUNT];
  logic              adv;
  logic              valid_s [STAGE_COUNT+1];
  tea_blk_t          blk_s   [STAGE_COUNT+1];
  tea_blk_t          out_blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        key_q[i] <= KEY_RESET[i];
      end
    end else if (cfg_we_i) begin
      case (key_idx_e'(cfg_idx_i))
        KEY_IDX_0: key_q[0] <= cfg_wdata_i;
        KEY_IDX_1: key_q[1] <= cfg_wdata_i;
        KEY_IDX_2: key_q[2] <= cfg_wdata_i;
        KEY_IDX_3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = adv;
  assign valid_s[0] = in_valid_i;
  assign blk_s[0]   = '{left: plain_left_i, right: plain_right_i};

  for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
    localparam int unsigned RND = g / 2 + 1;
    localparam half_e HALF = ((g % 2) == 0) ? HALF_LEFT : HALF_RIGHT;

    tea_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .half_i  (HALF),
      .sum_i   (round_sum(RND)),
      .ka_i    ((HALF == HALF_LEFT) ? key_q[0] : key_q[2]),
      .kb_i    ((HALF == HALF_LEFT) ? key_q[1] : key_q[3]),
      .valid_i (valid_s[g]),
      .blk_i   (blk_s[g]),
      .valid_o (valid_s[g+1]),
      .blk_o   (blk_s[g+1])
    );
  end

  tea_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .last_valid_i (valid_s[STAGE_COUNT]),
    .last_blk_i   (blk_s[STAGE_COUNT]),
    .out_ready_i  (out_ready_i),
    .adv_o        (adv),
    .out_valid_o  (out_valid_o),
    .out_blk_o    (out_blk)
  );

  assign cipher_left_o  = out_blk.left;
  assign cipher_right_o = out_blk.right;

endmodule

// ===== hdl/tea_block_encrypt_chk.sv =====
// Port-level checker for the TEA block encryptor, bound to the top level.
// Depends on tea_pkg and tea_block_encrypt_assert.svh.
`include "tea_block_encrypt_assert.svh"

module tea_block_encrypt_chk import tea_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [WORD_W-1:0]    plain_left_i,
  input logic [WORD_W-1:0]    plain_right_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [WORD_W-1:0]    cipher_left_o,
  input logic [WORD_W-1:0]    cipher_right_o
);

  // The input side only closes when a finished word was refused by the consumer.
  `TEA_ASSERT_NEXT(a_ready_drop, in_ready_o && !(out_valid_o && !out_ready_i), in_ready_o)

  // A closed input side means a word is held in the skid register.
  `TEA_ASSERT_NOW(a_stall_has_word, !in_ready_o, out_valid_o)

  // A refused output word stays put.
  `TEA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(cipher_left_o) && $stable(cipher_right_o))

  // A waiting input word stays put.
  `TEA_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
                   in_valid_i && $stable(plain_left_i) && $stable(plain_right_i))

  // Nothing leaves the pipeline in the first cycle after reset.
  `TEA_ASSERT_NOW(a_reset_empty, !$past(rst_ni), !out_valid_o && in_ready_o)

endmodule

bind tea_block_encrypt tea_block_encrypt_chk u_chk (.*);

// ===== verif/tea_block_encrypt_checker.sv =====
// Checker for the TEA block encryptor: tracks the key registers, predicts
// each cipher word from the accepted plaintext words and compares in order.
// Depends on tea_pkg for widths, key indexes, the delta and the key defaults.
`timescale 1ns / 100ps

module tea_block_encrypt_checker import tea_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [WORD_W-1:0]    plain_left_i,
  input  logic [WORD_W-1:0]    plain_right_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [WORD_W-1:0]    cipher_left_i,
  input  logic [WORD_W-1:0]    cipher_right_i,
  output int                   err_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  logic [WORD_W-1:0] key_q [KEY_COUNT];
  tea_blk_t          cipher_q [$];

  function automatic tea_blk_t encipher(tea_blk_t blk);
    logic [WORD_W-1:0] l;
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] s;
    l = blk.left;
    r = blk.right;
    s = '0;
    for (int n = 0; n < ROUND_COUNT; n++) begin
      s = s + TEA_DELTA;
      l = l + (((r << 4) + key_q[KEY_IDX_0]) ^ (r + s) ^ ((r >> 5) + key_q[KEY_IDX_1]));
      r = r + (((l << 4) + key_q[KEY_IDX_2]) ^ (l + s) ^ ((l >> 5) + key_q[KEY_IDX_3]));
    end
    encipher.left  = l;
    encipher.right = r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tea_blk_t plain;
    tea_blk_t want;
    if (!rst_ni) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        key_q[i] <= KEY_RESET[i];
      end
      cipher_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        plain.left  = plain_left_i;
        plain.right = plain_right_i;
        cipher_q.push_back(encipher(plain));
      end
      if (out_valid_i && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          $display("%0t: unexpected cipher word %h %h", $time, cipher_left_i, cipher_right_i);
          err_count_o <= err_count_o + 1;
        end else begin
          want = cipher_q.pop_front();
          checked_o <= checked_o + 1;
          if (want.left !== cipher_left_i || want.right !== cipher_right_i) begin
            $display("%0t: cipher mismatch, expected %h %h, actual %h %h", $time,
                     want.left, want.right, cipher_left_i, cipher_right_i);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        key_q[cfg_idx_i] <= cfg_wdata_i;
      end
      pending_o <= cipher_q.size();
    end
  end

endmodule

// ===== verif/tea_block_encrypt_tb.sv =====
// Testbench top for the TEA block encryptor: drives plaintext words and key
// writes with random stalls on both sides and reports the verdict.
// Depends on tea_pkg, tea_block_encrypt and tea_block_encrypt_checker.
`timescale 1ns / 100ps

module tea_block_encrypt_tb;
  import tea_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 225;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b1;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = KEY_IDX_0;
  logic [WORD_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [WORD_W-1:0]    plain_left_i = '0;
  logic [WORD_W-1:0]    plain_right_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [WORD_W-1:0]    cipher_left_o;
  logic [WORD_W-1:0]    cipher_right_o;

  int   err_count;
  int   pending;
  int   checked;
  int   sent = 0;
  int   key_sets = 1;
  int   idle_cycles = 0;
  int   rx_wait = 0;
  logic rx_calm = 1'b0;
  logic tx_calm = 1'b0;

  always #5 clk_i = ~clk_i;

  tea_block_encrypt dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .plain_left_i, .plain_right_i,
    .out_valid_o, .out_ready_i, .cipher_left_o, .cipher_right_o
  );

  tea_block_encrypt_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .plain_left_i, .plain_right_i,
    .out_valid_i(out_valid_o), .out_ready_i, .cipher_left_i(cipher_left_o),
    .cipher_right_i(cipher_right_o), .err_count_o(err_count), .pending_o(pending),
    .checked_o(checked)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    int draw;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
    end else if (out_valid_o && out_ready_i) begin
      draw = rx_calm ? 0 : $urandom_range(0, 9);
      rx_wait     <= draw;
      out_ready_i <= (draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait     <= rx_wait - 1;
      out_ready_i <= (rx_wait == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_block(input logic [WORD_W-1:0] l, input logic [WORD_W-1:0] r);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    plain_left_i  <= l;
    plain_right_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_key(input key_idx_e idx, input logic [WORD_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
  endtask

  task automatic load_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    write_key(KEY_IDX_0, k0);
    write_key(KEY_IDX_1, k1);
    write_key(KEY_IDX_2, k2);
    write_key(KEY_IDX_3, k3);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_sets++;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       pick_word = '0;
      1:       pick_word = '1;
      2:       pick_word = 32'h1 << $urandom_range(0, 31);
      3:       pick_word = ~(32'h1 << $urandom_range(0, 31));
      default: pick_word = $urandom;
    endcase
  endfunction

  initial begin
    logic [WORD_W-1:0] k [KEY_COUNT];
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_calm = 1'b0;
    send_block('0, '0);
    send_block('1, '1);
    send_block('0, '1);
    send_block('1, '0);
    send_block(32'h80000000, 32'h00000001);
    send_block(32'h00000001, 32'h80000000);
    send_block(32'h55555555, 32'haaaaaaaa);
    send_block(32'haaaaaaaa, 32'h55555555);
    send_block(32'h01234567, 32'h89abcdef);
    send_block(32'hdeadbeef, 32'h0badf00d);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       k = '{'0, '0, '0, '0};
        1:       k = '{'1, '1, '1, '1};
        2:       k = '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa};
        default: k = '{$urandom, $urandom, $urandom, $urandom};
      endcase
      load_keys(k[0], k[1], k[2], k[3]);
      if (p < 2) begin
        send_block('0, '0);
        send_block('1, '1);
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 45 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm <= ($urandom_range(0, 3) == 0);
        end
        send_block(pick_word(), pick_word());
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    $display("Encrypted %0d blocks under %0d key settings, %0d cipher words checked,",
             sent, key_sets, checked);
    $display("with random input gaps and output stalls, %0d mismatches.", err_count);
    if (err_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
